FILE: sv/cpd_pkg.sv
// Shared constants and types for the column post downscaler.
package cpd_pkg;

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] COLUMN_TERMINATOR = 8'hff;
   localparam logic [BYTE_W-1:0] PAD_VALUE         = 8'h00;

   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LENGTH = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PAD1   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PIXELS = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAD2   = 3'd4;

   typedef struct packed {
      logic              keep;
      logic [BYTE_W-1:0] out_byte;
      logic              column_end;
   } cpd_result_type;

endpackage

FILE: sv/cpd_decoder.sv
// Post phase tracker: state registers and per-byte result decode.
module cpd_decoder
   import cpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] item_byte,
   input  logic              advance,
   output cpd_result_type    result
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  pixels_left_ff, pixels_left_in;
   logic               odd_position_ff, odd_position_in;
   logic [BYTE_W-1:0]  pixels_dec;

   assign pixels_dec = (pixels_left_ff != '0) ? pixels_left_ff - 1'b1 : pixels_left_ff;

   always_comb begin
      phase_in          = phase_ff;
      pixels_left_in    = pixels_left_ff;
      odd_position_in   = odd_position_ff;
      result.keep       = 1'b1;
      result.out_byte   = PAD_VALUE;
      result.column_end = 1'b0;
      unique case (phase_ff)
         PH_LENGTH: begin
            pixels_left_in  = item_byte;
            odd_position_in = 1'b0;
            phase_in        = PH_PAD1;
            result.out_byte = item_byte;
         end
         PH_PAD1: begin
            phase_in = (pixels_left_ff != '0) ? PH_PIXELS : PH_PAD2;
         end
         PH_PIXELS: begin
            // even positions only, and never the odd last pixel
            result.keep     = !odd_position_ff && (pixels_left_ff >= BYTE_W'(2));
            result.out_byte = item_byte;
            odd_position_in = !odd_position_ff;
            pixels_left_in  = pixels_dec;
            if (pixels_dec == '0) begin
               phase_in = PH_PAD2;
            end
         end
         PH_PAD2: begin
            phase_in = PH_START;
         end
         default: begin
            result.out_byte = item_byte;
            if (item_byte == COLUMN_TERMINATOR) begin
               phase_in          = PH_START;
               result.column_end = 1'b1;
            end else begin
               phase_in = PH_LENGTH;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         pixels_left_ff  <= '0;
         odd_position_ff <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         pixels_left_ff  <= pixels_left_in;
         odd_position_ff <= odd_position_in;
      end
   end

endmodule

FILE: sv/column_post_downscaler_core.sv
// Top level of the column post downscaler.
//
// Usage: source column bytes enter on the req_ channel, one byte per transfer
// (req_valid / req_stall). Downscaled bytes leave on the rsp_ channel
// (rsp_valid / rsp_stall) with rsp_column_end high on the echoed 0xff
// terminator. Offset and length bytes pass unchanged, pad bytes come out as
// zero, and only pixels at even positions below 2*(n/2) are kept; other
// pixel bytes are consumed without a result.
// Data path: a byte is captured in the input register, decoded, and lands in
// the output register.
// Throughput: one byte per cycle while req_stall is low, set by the phase update
// in cpd_decoder. Bytes that produce no result never wait on the output side.
// Stall: while rsp_stall holds a result, the output register keeps it and
// the input register may still take one more byte; req_stall rises only when
// that held byte needs the occupied output register.
// Reset: synchronous, active high; both registers empty, column parser
// waiting for the start of a post.
module column_post_downscaler_core
   import cpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_column_end
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_end_ff;
   logic              out_free;
   logic              advance;
   logic              req_take;
   cpd_result_type    result;

   cpd_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .item_byte (in_byte_ff),
      .advance   (advance),
      .result    (result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!result.keep || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && result.keep) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance && result.keep) begin
         rsp_byte_ff <= result.out_byte;
         rsp_end_ff  <= result.column_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_column_end = rsp_end_ff;

   a_end_is_terminator: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_column_end |-> rsp_out_byte == COLUMN_TERMINATOR)
      else $error("column end flagged on a non-terminator byte");

   a_stall_needs_held_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !in_valid_ff)
      else $error("registers not empty after reset");

endmodule

FILE: sim/column_post_downscaler_checker.sv
// Checker for the column post downscaler: predicts each transfer's result and compares.
`timescale 1ns / 100ps

module column_post_downscaler_checker
   import cpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              rsp_column_end,
   output int                failures,
   output int                pending
);

   logic [PHASE_W-1:0] post_phase;
   logic [BYTE_W-1:0]  pixels_left;
   logic               odd_pixel;
   cpd_result_type     expected_bytes[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   // Advances the post parser by one source byte; keep is set when a byte comes out.
   function automatic cpd_result_type downscale_byte(input logic [BYTE_W-1:0] b);
      cpd_result_type r;
      r = '0;
      case (post_phase)
         PH_LENGTH: begin
            pixels_left = b;
            odd_pixel   = 1'b0;
            post_phase  = PH_PAD1;
            r.keep      = 1'b1;
            r.out_byte  = b;
         end
         PH_PAD1: begin
            post_phase = (pixels_left != '0) ? PH_PIXELS : PH_PAD2;
            r.keep     = 1'b1;
            r.out_byte = PAD_VALUE;
         end
         PH_PIXELS: begin
            // odd positions and an odd last pixel are dropped
            if (!odd_pixel && pixels_left >= 2) begin
               r.keep     = 1'b1;
               r.out_byte = b;
            end
            odd_pixel = ~odd_pixel;
            if (pixels_left != '0) pixels_left = pixels_left - 1'b1;
            if (pixels_left == '0) post_phase = PH_PAD2;
         end
         PH_PAD2: begin
            post_phase = PH_START;
            r.keep     = 1'b1;
            r.out_byte = PAD_VALUE;
         end
         default: begin
            r.keep     = 1'b1;
            r.out_byte = b;
            if (b == COLUMN_TERMINATOR) begin
               post_phase   = PH_START;
               r.column_end = 1'b1;
            end else begin
               post_phase = PH_LENGTH;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      cpd_result_type predicted;
      cpd_result_type want;
      if (reset) begin
         post_phase  = PH_START;
         pixels_left = '0;
         odd_pixel   = 1'b0;
         expected_bytes.delete();
      end else begin
         // a result always trails its source byte, so retire before queueing
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: rsp_out_byte %02h rsp_column_end %0b",
                      rsp_out_byte, rsp_column_end);
               failures++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("rsp_out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  failures++;
               end
               if (rsp_column_end !== want.column_end) begin
                  $error("rsp_column_end: expected %0b, got %0b",
                         want.column_end, rsp_column_end);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predicted = downscale_byte(req_data_byte);
            if (predicted.keep) expected_bytes = {expected_bytes, predicted};
         end
      end
      pending = expected_bytes.size();
   end

endmodule

FILE: sim/column_post_downscaler_core_tb.sv
// Testbench top for the column post downscaler: column stimulus, flow control and verdict.
`timescale 1ns / 100ps

module column_post_downscaler_core_tb;
   import cpd_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_column_end;
   int                failures;
   int                pending;

   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   logic        long_hold_req;
   int          bytes_sent;

   column_post_downscaler_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_column_end (rsp_column_end)
   );

   column_post_downscaler_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_column_end (rsp_column_end),
      .failures       (failures),
      .pending        (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off that backs the block up.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (64) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic put_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid     <= 1'b0;
         req_data_byte <= BYTE_W'($urandom);
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic put_post(input logic [BYTE_W-1:0] offset, input logic [BYTE_W-1:0] pixel_count);
      put_byte(offset);
      put_byte(pixel_count);
      put_byte(BYTE_W'($urandom));
      for (int i = 0; i < pixel_count; i++) put_byte(BYTE_W'($urandom));
      put_byte(BYTE_W'($urandom));
   endtask

   task automatic put_column();
      int unsigned        posts;
      int unsigned        pick;
      logic [BYTE_W-1:0]  pixel_count;
      posts = $urandom_range(4);
      for (int p = 0; p < posts; p++) begin
         pick = $urandom_range(99);
         if (pick < 82) pixel_count = BYTE_W'($urandom_range(15));
         else if (pick < 97) pixel_count = BYTE_W'($urandom_range(63, 16));
         else pixel_count = BYTE_W'($urandom_range(255, 64));
         put_post(BYTE_W'($urandom_range(254)), pixel_count);
      end
      put_byte(COLUMN_TERMINATOR);
   endtask

   // Noise: raw bytes that leave the parser wherever they leave it, often with terminators.
   task automatic put_noise();
      int unsigned count;
      count = $urandom_range(8, 1);
      repeat (count) begin
         if ($urandom_range(3) == 0) put_byte(COLUMN_TERMINATOR);
         else put_byte(BYTE_W'($urandom));
      end
   endtask

   initial begin : stimulus
      int phase_start;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      sender_idle_pct   = 17;
      receiver_idle_pct = 48;
      long_hold_req     = 1'b0;
      bytes_sent        = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty column, zero-length post with nonzero pads, odd last pixel, even and odd lengths
      put_byte(COLUMN_TERMINATOR);
      put_byte(8'h00); put_byte(8'h00); put_byte(8'hff); put_byte(8'haa);
      put_byte(8'hfe); put_byte(8'h01); put_byte(8'h55); put_byte(8'hff); put_byte(8'hff);
      put_byte(8'h80); put_byte(8'h02); put_byte(8'h01); put_byte(8'h01); put_byte(8'hfe);
      put_byte(8'h7f);
      put_byte(8'h7f); put_byte(8'h03); put_byte(8'hff); put_byte(8'hff); put_byte(8'h00);
      put_byte(8'h80); put_byte(8'h5a);
      put_byte(COLUMN_TERMINATOR);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 17;
               receiver_idle_pct = 48;
            end
            1: begin
               sender_idle_pct   = 48;
               receiver_idle_pct = 17;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               long_hold_req     = 1'b1;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 383) begin
            if ($urandom_range(9) == 0) put_noise();
            else put_column();
         end
      end
      req_valid <= 1'b0;

      for (int w = 0; w < 20000 && pending != 0; w++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (pending != 0) $error("%0d expected results never arrived", pending);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
